// ===== sv/tvsd_pkg.sv =====
// Shared types and constants for the tagged value stream decoder.
package tvsd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_BODY    = 3'd2,
        PH_CHAR    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    localparam logic [2:0] K_BOOL  = 3'd0;
    localparam logic [2:0] K_SHORT = 3'd1;
    localparam logic [2:0] K_INT   = 3'd2;
    localparam logic [2:0] K_LONG  = 3'd3;
    localparam logic [2:0] K_CHAR  = 3'd4;
    localparam logic [2:0] K_SLEN  = 3'd5;
    localparam logic [2:0] K_SBYTE = 3'd6;
    localparam logic [2:0] K_ERROR = 3'd7;

    localparam logic [1:0] E_NONE = 2'd0;
    localparam logic [1:0] E_TAG  = 2'd1;
    localparam logic [1:0] E_END  = 2'd2;

    localparam logic [7:0] TAG_TRUE  = 8'h74;
    localparam logic [7:0] TAG_FALSE = 8'h66;
    localparam logic [7:0] TAG_CHAR  = 8'h63;
    localparam logic [7:0] TAG_SHORT = 8'h73;
    localparam logic [7:0] TAG_INT   = 8'h69;
    localparam logic [7:0] TAG_LONG  = 8'h6c;
    localparam logic [7:0] TAG_STR   = 8'h53;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

endpackage

// ===== sv/tvsd_core.sv =====
// Decode state machine: updates state and forms up to two results per item.
module tvsd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        data_byte,
    input  logic              end_of_input,
    output tvsd_pkg::result_t res0,
    output tvsd_pkg::result_t res1,
    output logic [1:0]        res_count
);
    import tvsd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  tag_reg, tag_next;
    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic [63:0] acc_reg, acc_next;
    logic [30:0] payload_left_reg, payload_left_next;

    logic [63:0] acc_new;
    logic [3:0]  bl_new;
    logic        num_done;
    logic [31:0] len32;
    logic        len_zero;
    logic [30:0] pl_new;
    logic        pl_zero;
    logic        tag_num;
    logic        tag_ok;
    logic [2:0]  tag_kind;

    always_comb
    begin
        if (phase_reg == PH_HEADER)
        begin
            acc_new = {{60{data_byte[3]}}, data_byte[3:0]};
            bl_new  = data_byte[7:4];
        end
        else
        begin
            acc_new = {acc_reg[55:0], data_byte};
            bl_new  = bytes_left_reg - 4'd1;
        end
        num_done = ((phase_reg == PH_HEADER) || (phase_reg == PH_BODY)) && (bl_new == 4'd0);
        len32    = acc_new[31] ? 32'd0 : acc_new[31:0];
        len_zero = (len32 == 32'd0);
        pl_new   = payload_left_reg - 31'd1;
        pl_zero  = (pl_new == 31'd0);
        tag_num  = (data_byte == TAG_SHORT) || (data_byte == TAG_INT) ||
                   (data_byte == TAG_LONG) || (data_byte == TAG_STR);
        tag_ok   = tag_num || (data_byte == TAG_CHAR);
        priority if (data_byte == TAG_SHORT)
            tag_kind = K_SHORT;
        else if (data_byte == TAG_INT)
            tag_kind = K_INT;
        else if (data_byte == TAG_LONG)
            tag_kind = K_LONG;
        else
            tag_kind = K_SLEN;
    end

    // next state
    always_comb
    begin
        phase_next        = PH_IDLE;
        tag_next          = tag_reg;
        bytes_left_next   = bytes_left_reg;
        acc_next          = acc_reg;
        payload_left_next = payload_left_reg;
        unique case (phase_reg)
            PH_HEADER, PH_BODY:
            begin
                bytes_left_next = bl_new;
                acc_next        = acc_new;
                if (num_done)
                begin
                    if ((tag_reg == K_SLEN) && !len_zero)
                    begin
                        phase_next        = end_of_input ? PH_IDLE : PH_PAYLOAD;
                        payload_left_next = end_of_input ? 31'd0 : len32[30:0];
                    end
                end
                else if (end_of_input)
                    bytes_left_next = 4'd0;
                else
                    phase_next = PH_BODY;
            end
            PH_CHAR:
                phase_next = PH_IDLE;
            PH_PAYLOAD:
            begin
                payload_left_next = (end_of_input && !pl_zero) ? 31'd0 : pl_new;
                phase_next        = (pl_zero || end_of_input) ? PH_IDLE : PH_PAYLOAD;
            end
            default:
            begin
                if (tag_num)
                    tag_next = tag_kind;
                if (tag_ok && end_of_input)
                    bytes_left_next = 4'd0;
                else if (data_byte == TAG_CHAR)
                    phase_next = PH_CHAR;
                else if (tag_num)
                    phase_next = PH_HEADER;
            end
        endcase
    end

    // results
    always_comb
    begin
        res0      = '{kind: K_ERROR, value: 64'd0, error_code: E_END, last: 1'b1};
        res1      = '{kind: K_ERROR, value: 64'd0, error_code: E_END, last: 1'b1};
        res_count = 2'd0;
        unique case (phase_reg)
            PH_HEADER, PH_BODY:
            begin
                if (num_done)
                begin
                    res_count = 2'd1;
                    if (tag_reg == K_SLEN)
                    begin
                        res0 = '{kind: K_SLEN, value: {32'd0, len32},
                                 error_code: E_NONE, last: len_zero};
                        if (!len_zero && end_of_input)
                            res_count = 2'd2;
                    end
                    else
                        res0 = '{kind: tag_reg, value: acc_new, error_code: E_NONE, last: 1'b1};
                end
                else if (end_of_input)
                    res_count = 2'd1;
            end
            PH_CHAR:
            begin
                res0      = '{kind: K_CHAR, value: {{56{data_byte[7]}}, data_byte},
                              error_code: E_NONE, last: 1'b1};
                res_count = 2'd1;
            end
            PH_PAYLOAD:
            begin
                res0      = '{kind: K_SBYTE, value: {56'd0, data_byte},
                              error_code: E_NONE, last: pl_zero};
                res_count = (!pl_zero && end_of_input) ? 2'd2 : 2'd1;
            end
            default:
            begin
                priority if (data_byte == TAG_TRUE)
                begin
                    res0      = '{kind: K_BOOL, value: 64'd1, error_code: E_NONE, last: 1'b1};
                    res_count = 2'd1;
                end
                else if (data_byte == TAG_FALSE)
                begin
                    res0      = '{kind: K_BOOL, value: 64'd0, error_code: E_NONE, last: 1'b1};
                    res_count = 2'd1;
                end
                else if (tag_ok)
                    res_count = end_of_input ? 2'd1 : 2'd0;
                else
                begin
                    res0      = '{kind: K_ERROR, value: {56'd0, data_byte},
                                  error_code: E_TAG, last: 1'b1};
                    res_count = 2'd1;
                end
            end
        endcase
        if (!fire)
            res_count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tag_reg          <= 3'd0;
            bytes_left_reg   <= 4'd0;
            acc_reg          <= 64'd0;
            payload_left_reg <= 31'd0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            tag_reg          <= tag_next;
            bytes_left_reg   <= bytes_left_next;
            acc_reg          <= acc_next;
            payload_left_reg <= payload_left_next;
        end
    end

endmodule

// ===== sv/tagged_value_stream_decoder.sv =====
// Top level: tagged value stream decoder with its result queue.
// A result is written to the four-entry result queue when its item is accepted and is offered from its head.
// Throughput: one item per cycle while in_ready is high; results leave one per cycle on out_ready.
// A nonzero string length or a non-final payload byte that ends the input yields two results.
// in_ready is high while the queue has room for two results.
// Reset (rst_n low, asynchronous) returns the decoder to idle and empties the queue.
module tagged_value_stream_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_of_input,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         kind,
    output logic signed [63:0] value,
    output logic [1:0]         error_code,
    output logic               last
);
    import tvsd_pkg::*;

    result_t        res0, res1;
    logic [1:0]     res_count;
    logic           fire;
    logic           pop;

    result_t        q_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    assign in_ready  = (count_reg <= QCW'(QDEPTH - 2));
    assign fire      = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;

    tvsd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .res0         (res0),
        .res1         (res1),
        .res_count    (res_count)
    );

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QAW'(res_count);
        rd_ptr_next = rd_ptr_reg + QAW'(pop);
        count_next  = count_reg + QCW'(res_count) - QCW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (res_count != 2'd0)
            q_reg[wr_ptr_reg] <= res0;
        if (res_count == 2'd2)
            q_reg[wr_ptr_reg + QAW'(1)] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign kind       = q_reg[rd_ptr_reg].kind;
    assign value      = $signed(q_reg[rd_ptr_reg].value);
    assign error_code = q_reg[rd_ptr_reg].error_code;
    assign last       = q_reg[rd_ptr_reg].last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QDEPTH))
        else $error("result queue overflow");

    a_second_is_error: assert property (@(posedge clk) disable iff (!rst_n)
        (res_count == 2'd2) |-> (res1.kind == K_ERROR && res1.error_code == E_END
                                 && res0.last == 1'b0))
        else $error("second result of an item is not an end-of-input error");

    a_push_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (res_count != 2'd0) |-> fire)
        else $error("results pushed without an accepted item");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (!fire && !pop) |=> $stable(count_reg))
        else $error("queue count changed while idle");

endmodule
